// ----- sv/dda_pkg.sv -----
// Shared types and codes for the DDA line rasteriser.
// No dependencies; used by dda_div and dda_line_rasterizer_core.
package dda_pkg;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- sv/dda_if.sv -----
// Valid/ready channel interfaces for the DDA line rasteriser.
// No dependencies; used by dda_line_rasterizer_core.
interface dda_in_if #(
    parameter int CW = 12
) ();
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic signed [CW-1:0] x_start;
    logic signed [CW-1:0] y_start;
    logic signed [CW-1:0] x_end;
    logic signed [CW-1:0] y_end;

    modport source (output valid, mode, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, mode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dda_out_if #(
    parameter int CW = 12
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// ----- sv/dda_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on dda_pkg (t_div_stat).
module dda_div #(
    parameter int N_W = 29,
    parameter int D_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N_W-1:0]    i_num,
    input  logic [D_W-1:0]    i_den,
    output dda_pkg::t_div_stat o_stat,
    output logic [N_W-1:0]    o_quo
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [N_W-1:0]   r_quo, n_quo;
    logic [D_W-1:0]   r_den, n_den;

    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    always_comb begin
        trial  = {r_rem, r_quo[N_W-1]};
        diff   = trial - {1'b0, r_den};
        fits   = trial >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = fits ? diff[D_W-1:0] : trial[D_W-1:0];
            n_quo = {r_quo[N_W-2:0], fits};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(N_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
endmodule

// ----- sv/dda_line_rasterizer_core.sv -----
// DDA line rasteriser top level: line set-up sequencer, stepping datapath, output register.
// Depends on dda_pkg, dda_if (dda_in_if, dda_out_if) and dda_div.
//
// Usage:
//   i_in carries items. mode = start loads two endpoints and produces no point;
//   mode = step produces the next pixel of the loaded line on o_out, or nothing
//   when no line is loaded or the line is finished. The final pixel has
//   last_point set; the end point itself is never produced.
//   A start item runs the slope division on the bit-serial divider: i_in.ready
//   stays low after the start transfer through set-up, launch, the quotient
//   bits and write-back.
//   A zero-length line skips the division; ready is low only for set-up.
//   Step items give one pixel per cycle while o_out does not stall, each
//   appearing on o_out in the cycle after the step transfer.
//   The output register is the only buffer: when the sink stalls with a pixel
//   held, i_in.ready drops until that pixel is transferred.
//   Reset (synchronous, active low) leaves no line loaded and o_out empty.
module dda_line_rasterizer_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dda_in_if.sink     i_in,
    dda_out_if.source  o_out
);
    localparam int CW    = COORD_BITS;
    localparam int ACC_W = COORD_BITS + FRAC_BITS;
    localparam int N_W   = COORD_BITS + FRAC_BITS + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV} t_state;

    t_state             r_state, n_state;
    logic               r_active, n_active;
    logic               r_ovld, n_ovld;
    logic [CW-1:0]      r_px, n_px;
    logic [CW-1:0]      r_py, n_py;
    logic               r_last, n_last;
    logic [CW-1:0]      r_major_pos, n_major_pos;
    logic [CW-1:0]      r_major_tgt, n_major_tgt;
    logic               r_dir, n_dir;
    logic               r_xmaj, n_xmaj;
    logic               r_minor_neg, n_minor_neg;
    logic [CW-1:0]      r_amaj, n_amaj;
    logic [CW-1:0]      r_amin, n_amin;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [N_W-1:0]     r_slope, n_slope;

    logic               in_xfer, out_xfer;
    logic [CW:0]        dx, dy, adx_w, ady_w;
    logic [CW-1:0]      adx, ady;
    logic               x_major;
    logic [ACC_W-1:0]   rnd;
    logic [CW-1:0]      minor_out;
    logic [CW-1:0]      next_pos;
    logic               step_last;
    logic               div_start;
    logic [N_W-1:0]     div_num;
    logic [N_W-1:0]     div_quo;
    dda_pkg::t_div_stat div_stat;

    assign i_in.ready = (r_state == ST_IDLE) && (!r_ovld || o_out.ready);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = r_ovld && o_out.ready;

    assign dx    = {i_in.x_end[CW-1], i_in.x_end} - {i_in.x_start[CW-1], i_in.x_start};
    assign dy    = {i_in.y_end[CW-1], i_in.y_end} - {i_in.y_start[CW-1], i_in.y_start};
    assign adx_w = dx[CW] ? ((CW+1)'(0) - dx) : dx;
    assign ady_w = dy[CW] ? ((CW+1)'(0) - dy) : dy;
    assign adx   = adx_w[CW-1:0];
    assign ady   = ady_w[CW-1:0];
    assign x_major = adx > ady;

    assign rnd       = r_acc + {{CW{1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    assign minor_out = rnd[ACC_W-1:FRAC_BITS];
    assign next_pos  = r_major_pos + (r_dir ? {CW{1'b1}} : CW'(1));
    assign step_last = next_pos == r_major_tgt;

    assign div_num = {1'b0, r_amin, {FRAC_BITS{1'b0}}}
                   + {{(FRAC_BITS+2){1'b0}}, r_amaj[CW-1:1]};

    dda_div #(
        .N_W (N_W),
        .D_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_amaj),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_ovld      = r_ovld;
        n_px        = r_px;
        n_py        = r_py;
        n_last      = r_last;
        n_major_pos = r_major_pos;
        n_major_tgt = r_major_tgt;
        n_dir       = r_dir;
        n_xmaj      = r_xmaj;
        n_minor_neg = r_minor_neg;
        n_amaj      = r_amaj;
        n_amin      = r_amin;
        n_acc       = r_acc;
        n_slope     = r_slope;
        div_start   = 1'b0;

        if (out_xfer) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in.mode == dda_pkg::MODE_START) begin
                    n_active    = 1'b0;
                    n_xmaj      = x_major;
                    n_major_pos = x_major ? i_in.x_start : i_in.y_start;
                    n_major_tgt = x_major ? i_in.x_end : i_in.y_end;
                    n_dir       = x_major ? dx[CW] : dy[CW];
                    n_minor_neg = x_major ? dy[CW] : dx[CW];
                    n_amaj      = x_major ? adx : ady;
                    n_amin      = x_major ? ady : adx;
                    n_acc       = {(x_major ? i_in.y_start : i_in.x_start),
                                   {FRAC_BITS{1'b0}}};
                    n_state     = ST_LOAD;
                end else if (in_xfer && r_active) begin
                    n_ovld      = 1'b1;
                    n_px        = r_xmaj ? r_major_pos : minor_out;
                    n_py        = r_xmaj ? minor_out : r_major_pos;
                    n_last      = step_last;
                    n_major_pos = next_pos;
                    n_acc       = r_acc + r_slope[ACC_W-1:0];
                    if (step_last) begin
                        n_active = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                if (r_amaj == '0) begin
                    n_slope = '0;
                    n_state = ST_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_slope  = r_minor_neg ? (N_W'(0) - div_quo) : div_quo;
                    n_active = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_ovld   <= n_ovld;
        end
        r_px        <= n_px;
        r_py        <= n_py;
        r_last      <= n_last;
        r_major_pos <= n_major_pos;
        r_major_tgt <= n_major_tgt;
        r_dir       <= n_dir;
        r_xmaj      <= n_xmaj;
        r_minor_neg <= n_minor_neg;
        r_amaj      <= n_amaj;
        r_amin      <= n_amin;
        r_acc       <= n_acc;
        r_slope     <= n_slope;
    end

    assign o_out.valid      = r_ovld;
    assign o_out.point_x    = r_px;
    assign o_out.point_y    = r_py;
    assign o_out.last_point = r_last;

`ifndef ASSERT_OFF
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == ST_DIV)
        else $error("divider finished outside the division state");

    a_busy_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> r_state != ST_IDLE)
        else $error("divider running while the sequencer is idle");

    a_active_not_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_major_pos != r_major_tgt)
        else $error("active line already at its end point");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.mode == dda_pkg::MODE_STEP && r_active && step_last)
        |=> !r_active && r_ovld && r_last)
        else $error("final pixel did not end the line");
`endif
endmodule

// ----- tb/dda_line_rasterizer_core_check.sv -----
// Scoreboard for the DDA line rasteriser: watches both channels, predicts every pixel
// and compares it field by field. Depends on dda_pkg and dda_if.
module dda_line_rasterizer_core_check #(
    parameter int CW = 12,
    parameter int FB = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dda_in_if    in_ch,
    dda_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_pixels
);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } t_pixel;

    t_pixel pixel_q[$];

    logic signed [CW-1:0]    major_pos;
    logic signed [CW-1:0]    major_tgt;
    logic signed [CW+FB-1:0] minor_acc;
    logic signed [CW+FB:0]   minor_slope;
    logic                    major_down;
    logic                    x_major;
    logic                    drawing;
    int                      fails;
    int                      pixels;

    always @(posedge i_clk) begin : track
        logic signed [CW:0]    dx;
        logic signed [CW:0]    dy;
        logic signed [CW:0]    maj_d;
        logic signed [CW:0]    min_d;
        logic signed [CW-1:0]  min_start;
        logic [CW:0]           adx;
        logic [CW:0]           ady;
        logic [CW:0]           amaj;
        logic [CW:0]           amin;
        logic [CW+FB:0]        quot;
        logic signed [CW+FB:0] rounded;
        logic signed [CW:0]    next_pos;
        logic signed [CW-1:0]  minor_out;
        t_pixel                px;
        t_pixel                want;

        if (!i_rst_n) begin
            pixel_q.delete();
            major_pos   = '0;
            major_tgt   = '0;
            minor_acc   = '0;
            minor_slope = '0;
            major_down  = 1'b0;
            x_major     = 1'b0;
            drawing     = 1'b0;
            fails       = 0;
            pixels      = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                pixels++;
                if (pixel_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                             out_ch.point_x, out_ch.point_y, out_ch.last_point);
                end else begin
                    want = pixel_q.pop_front();
                    if (out_ch.point_x !== want.x) begin
                        fails++;
                        $display("%0t: point_x expected %0d got %0d", $time,
                                 want.x, out_ch.point_x);
                    end
                    if (out_ch.point_y !== want.y) begin
                        fails++;
                        $display("%0t: point_y expected %0d got %0d", $time,
                                 want.y, out_ch.point_y);
                    end
                    if (out_ch.last_point !== want.last) begin
                        fails++;
                        $display("%0t: last_point expected %0b got %0b", $time,
                                 want.last, out_ch.last_point);
                    end
                end
            end

            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.mode == dda_pkg::MODE_START) begin
                    dx  = (CW+1)'(in_ch.x_end) - (CW+1)'(in_ch.x_start);
                    dy  = (CW+1)'(in_ch.y_end) - (CW+1)'(in_ch.y_start);
                    adx = (dx < 0) ? -dx : dx;
                    ady = (dy < 0) ? -dy : dy;
                    // ties on |dx| == |dy| go to y
                    x_major = (adx > ady);
                    if (x_major) begin
                        major_pos = in_ch.x_start;
                        major_tgt = in_ch.x_end;
                        maj_d     = dx;
                        min_d     = dy;
                        min_start = in_ch.y_start;
                        amaj      = adx;
                        amin      = ady;
                    end else begin
                        major_pos = in_ch.y_start;
                        major_tgt = in_ch.y_end;
                        maj_d     = dy;
                        min_d     = dx;
                        min_start = in_ch.x_start;
                        amaj      = ady;
                        amin      = adx;
                    end
                    major_down = (maj_d < 0);
                    minor_acc  = {min_start, {FB{1'b0}}};
                    if (amaj == 0) begin
                        minor_slope = '0;
                        drawing     = 1'b0;
                    end else begin
                        quot        = (((CW+FB+1)'(amin) << FB) + (CW+FB+1)'(amaj >> 1))
                                    / (CW+FB+1)'(amaj);
                        minor_slope = (min_d < 0) ? -$signed(quot) : $signed(quot);
                        drawing     = 1'b1;
                    end
                end else if (drawing) begin
                    rounded   = (CW+FB+1)'(minor_acc);
                    rounded   = rounded + (CW+FB+1)'(1 <<< (FB - 1));
                    minor_out = rounded[FB +: CW];
                    next_pos  = (CW+1)'(major_pos + (major_down ? -1 : 1));
                    px.last   = (next_pos[CW-1:0] == major_tgt);
                    px.x      = x_major ? major_pos : minor_out;
                    px.y      = x_major ? minor_out : major_pos;
                    pixel_q.push_back(px);
                    major_pos = next_pos[CW-1:0];
                    minor_acc = minor_acc + minor_slope[CW+FB-1:0];
                    if (px.last)
                        drawing = 1'b0;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pixel_q.size();
        o_pixels     <= pixels;
    end

endmodule

// ----- tb/dda_line_rasterizer_core_test.sv -----
// Testbench top for dda_line_rasterizer_core: directed lines, then random line sequences
// under three handshake pressure phases. Depends on dda_pkg, dda_if, the core and the checker.
module dda_line_rasterizer_core_test;

    localparam int CW    = 12;
    localparam int FB    = 16;
    localparam int CMAX  = (1 << (CW - 1)) - 1;
    localparam int CMIN  = -(1 << (CW - 1));
    localparam int LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   pixels;
    int   cycle_cnt;
    int   tally;
    int   lines;
    int   send_idle;
    int   recv_idle;

    dda_in_if  #(.CW(CW)) in_ch ();
    dda_out_if #(.CW(CW)) out_ch ();

    dda_line_rasterizer_core #(
        .COORD_BITS (CW),
        .FRAC_BITS  (FB)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dda_line_rasterizer_core_check #(
        .CW (CW),
        .FB (FB)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pixels     (pixels)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("dda_line_rasterizer_core test failed");
            $finish;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_idle);
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic m, input logic signed [CW-1:0] xs,
                             input logic signed [CW-1:0] ys,
                             input logic signed [CW-1:0] xe,
                             input logic signed [CW-1:0] ye);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.mode    = m;
        in_ch.x_start = xs;
        in_ch.y_start = ys;
        in_ch.x_end   = xe;
        in_ch.y_end   = ye;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic feed_line(input logic signed [CW-1:0] xs, input logic signed [CW-1:0] ys,
                             input logic signed [CW-1:0] xe, input logic signed [CW-1:0] ye,
                             input int steps, input int len);
        send_item(dda_pkg::MODE_START, xs, ys, xe, ye);
        tally++;
        lines++;
        for (int k = 0; k < steps; k++) begin
            send_item(dda_pkg::MODE_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
                      CW'($urandom));
            if (k < len)
                tally++;
        end
    endtask

    task automatic random_line();
        int kind;
        int len;
        int steps;
        int tx;
        int ty;
        int d;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] ye;

        kind = $urandom_range(99);
        xs   = CW'($urandom);
        ys   = CW'($urandom);
        tx   = xs;
        ty   = ys;
        if (kind < 75) begin
            tx = tx + int'($urandom_range(40)) - 20;
            ty = ty + int'($urandom_range(40)) - 20;
        end else if (kind < 92) begin
            tx = int'($urandom_range(CMAX - CMIN)) + CMIN;
            ty = int'($urandom_range(CMAX - CMIN)) + CMIN;
        end else if (kind < 96) begin
            d = 0;
        end else begin
            d  = int'($urandom_range(40)) - 20;
            tx = tx + d;
            ty = ($urandom_range(1) != 0) ? ty + d : ty - d;
        end
        if (tx > CMAX) tx = CMAX;
        if (tx < CMIN) tx = CMIN;
        if (ty > CMAX) ty = CMAX;
        if (ty < CMIN) ty = CMIN;
        xe  = tx[CW-1:0];
        ye  = ty[CW-1:0];
        tx  = (tx > xs) ? tx - xs : xs - tx;
        ty  = (ty > ys) ? ty - ys : ys - ty;
        len = (tx > ty) ? tx : ty;
        // long lines and some short ones are cut off by the next start
        if (len > 60 || $urandom_range(99) < 20)
            steps = $urandom_range((len < 40) ? len : 40);
        else
            steps = len + $urandom_range(2);
        feed_line(xs, ys, xe, ye, steps, len);
    endtask

    initial begin : stimulus
        int goal;

        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = dda_pkg::MODE_START;
        in_ch.x_start = '0;
        in_ch.y_start = '0;
        in_ch.x_end   = '0;
        in_ch.y_end   = '0;
        tally         = 0;
        lines         = 0;
        send_idle     = 6;
        recv_idle     = 88;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // step with nothing loaded, zero-length line, diagonal tie, extremes,
        // restart mid-line, negative majors, half-pixel rounding
        send_item(dda_pkg::MODE_STEP, CW'(CMAX), CW'(CMIN), CW'(CMAX), CW'(CMIN));
        feed_line(5, 5, 5, 5, 1, 0);
        feed_line(0, 0, 3, 3, 4, 3);
        feed_line(CW'(CMIN), CW'(CMAX), CW'(CMAX), CW'(CMIN), 2, 4095);
        feed_line(CW'(CMAX), CW'(CMIN), CW'(CMIN), CW'(CMAX), 2, 4095);
        feed_line(0, 0, -4, 1, 4, 4);
        feed_line(1, 0, 1, -3, 3, 3);
        feed_line(0, 0, 2, 1, 2, 2);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 6 : (phase == 1) ? 88 : 0;
            recv_idle = (phase == 0) ? 88 : (phase == 1) ? 6 : 0;
            goal = tally + 400;
            if (phase == 2)
                feed_line(CW'(CMAX - 300), CW'(CMIN), CW'(CMAX), CW'(CMIN + 77), 301, 300);
            while (tally < goal)
                random_line();
        end

        in_ch.valid = 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d counted items over %0d lines, %0d pixels checked,", tally, lines,
                 pixels);
        $display("under sender-heavy, receiver-heavy and free-running handshake phases.");
        if (fail_count == 0)
            $display("dda_line_rasterizer_core test passed");
        else
            $display("dda_line_rasterizer_core test failed");
        $finish;
    end

endmodule
